/* sv/lmpd_pkg.sv */
package lmpd_pkg;

   localparam int PWM_BITS = 7;
   localparam int PIX_W    = 7;
   localparam int ROW_PIX  = 16;
   localparam int ROWS     = 16;
   localparam int ROW_W    = ROW_PIX * PIX_W;
   localparam int ROW_AW   = $clog2(ROWS);
   localparam int COL_AW   = $clog2(ROW_PIX);
   localparam int ADDR_W   = ROW_AW + COL_AW;
   localparam int CNT_W    = $clog2(ROWS + 1);
   localparam int CMP_W    = (PWM_BITS > PIX_W) ? PWM_BITS : PIX_W;

   localparam logic [1:0] KIND_DRAW    = 2'd0;
   localparam logic [1:0] KIND_SHOW    = 2'd1;
   localparam logic [1:0] KIND_REFRESH = 2'd2;

   typedef logic [PIX_W-1:0] pix_type;
   typedef logic [ROW_PIX-1:0][PIX_W-1:0] row_type;

   typedef struct packed {
      logic              capture;
      logic              draw_rd;
      logic              draw_wr;
      logic              copy_rd;
      logic              copy_wr;
      logic              frame_end;
      logic              phase_step;
      logic              row_rd;
      logic              out_load;
      logic              out_last;
      logic [ROW_AW-1:0] rd_row;
      logic [ROW_AW-1:0] row;
      logic [ROW_AW-1:0] prev_row;
   } cmd_type;

   typedef struct packed {
      logic in_range;
      logic blanked;
      logic out_free;
   } stat_type;

   localparam pix_type GAMMA_ROM [256] = '{
        7'd0,   7'd1,   7'd1,   7'd1,   7'd1,   7'd1,   7'd1,   7'd1,
        7'd1,   7'd1,   7'd1,   7'd1,   7'd1,   7'd1,   7'd1,   7'd1,
        7'd1,   7'd1,   7'd1,   7'd1,   7'd1,   7'd1,   7'd1,   7'd1,
        7'd1,   7'd1,   7'd1,   7'd1,   7'd1,   7'd1,   7'd1,   7'd1,
        7'd1,   7'd1,   7'd1,   7'd1,   7'd1,   7'd1,   7'd1,   7'd1,
        7'd1,   7'd1,   7'd1,   7'd2,   7'd2,   7'd2,   7'd2,   7'd2,
        7'd2,   7'd2,   7'd2,   7'd2,   7'd2,   7'd2,   7'd2,   7'd2,
        7'd3,   7'd3,   7'd3,   7'd3,   7'd3,   7'd3,   7'd3,   7'd3,
        7'd4,   7'd4,   7'd4,   7'd4,   7'd4,   7'd4,   7'd4,   7'd4,
        7'd5,   7'd5,   7'd5,   7'd5,   7'd5,   7'd5,   7'd6,   7'd6,
        7'd6,   7'd6,   7'd6,   7'd7,   7'd7,   7'd7,   7'd7,   7'd7,
        7'd8,   7'd8,   7'd8,   7'd8,   7'd9,   7'd9,   7'd9,   7'd9,
        7'd9,   7'd10,  7'd10,  7'd10,  7'd11,  7'd11,  7'd11,  7'd11,
        7'd12,  7'd12,  7'd12,  7'd13,  7'd13,  7'd13,  7'd13,  7'd14,
        7'd14,  7'd14,  7'd15,  7'd15,  7'd15,  7'd16,  7'd16,  7'd17,
        7'd17,  7'd17,  7'd18,  7'd18,  7'd18,  7'd19,  7'd19,  7'd20,
        7'd20,  7'd20,  7'd21,  7'd21,  7'd22,  7'd22,  7'd23,  7'd23,
        7'd24,  7'd24,  7'd24,  7'd25,  7'd25,  7'd26,  7'd26,  7'd27,
        7'd27,  7'd28,  7'd28,  7'd29,  7'd29,  7'd30,  7'd30,  7'd31,
        7'd32,  7'd32,  7'd33,  7'd33,  7'd34,  7'd34,  7'd35,  7'd36,
        7'd36,  7'd37,  7'd37,  7'd38,  7'd39,  7'd39,  7'd40,  7'd41,
        7'd41,  7'd42,  7'd43,  7'd43,  7'd44,  7'd45,  7'd45,  7'd46,
        7'd47,  7'd47,  7'd48,  7'd49,  7'd50,  7'd50,  7'd51,  7'd52,
        7'd53,  7'd53,  7'd54,  7'd55,  7'd56,  7'd56,  7'd57,  7'd58,
        7'd59,  7'd60,  7'd61,  7'd61,  7'd62,  7'd63,  7'd64,  7'd65,
        7'd66,  7'd67,  7'd67,  7'd68,  7'd69,  7'd70,  7'd71,  7'd72,
        7'd73,  7'd74,  7'd75,  7'd76,  7'd77,  7'd78,  7'd79,  7'd80,
        7'd81,  7'd82,  7'd83,  7'd84,  7'd85,  7'd86,  7'd87,  7'd88,
        7'd89,  7'd90,  7'd91,  7'd92,  7'd93,  7'd94,  7'd96,  7'd97,
        7'd98,  7'd99,  7'd100, 7'd101, 7'd102, 7'd104, 7'd105, 7'd106,
        7'd107, 7'd108, 7'd110, 7'd111, 7'd112, 7'd113, 7'd115, 7'd116,
        7'd117, 7'd118, 7'd120, 7'd121, 7'd122, 7'd124, 7'd125, 7'd126
   };

   // panel wiring: 64-pixel blocks of eight 8-pixel lines, snaking
   function automatic logic [ADDR_W-1:0] serp_addr(input logic [3:0] x, input logic [3:0] y);
      logic [7:0] lin;
      logic [2:0] col;
      logic [5:0] off;
      lin = {y, x};
      col = lin[2:0];
      unique case (lin[5:3])
         3'd0:    off = {3'd0, col};
         3'd1:    off = 6'd16 + {3'd0, col};
         3'd2:    off = 6'd15 - {3'd0, col};
         3'd3:    off = 6'd31 - {3'd0, col};
         3'd4:    off = 6'd48 + {3'd0, col};
         3'd5:    off = 6'd32 + {3'd0, col};
         3'd6:    off = 6'd63 - {3'd0, col};
         3'd7:    off = 6'd47 - {3'd0, col};
         default: off = {3'd0, col};
      endcase
      return {lin[7:6], off};
   endfunction

endpackage

/* sv/lmpd_ram.sv */
module lmpd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/lmpd_ctrl.sv */
module lmpd_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic [1:0]         req_kind,
   output logic               req_stall,
   input  lmpd_pkg::stat_type stat,
   output lmpd_pkg::cmd_type  cmd
);

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_DRAW_RD = 5'b00010,
      ST_DRAW_WR = 5'b00100,
      ST_COPY    = 5'b01000,
      ST_REFRESH = 5'b10000
   } state_type;

   state_type                    state_ff, state_in;
   logic [lmpd_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic [lmpd_pkg::ROW_AW-1:0]  cnt_row;

   assign cnt_row = cnt_ff[lmpd_pkg::ROW_AW-1:0];

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd          = '0;
      cmd.row      = cnt_row;
      cmd.prev_row = cnt_row - lmpd_pkg::ROW_AW'(1);
      cmd.rd_row   = cnt_row;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               cnt_in      = '0;
               unique case (req_kind)
                  lmpd_pkg::KIND_DRAW: begin
                     if (stat.in_range) begin
                        state_in = ST_DRAW_RD;
                     end
                  end
                  lmpd_pkg::KIND_SHOW: begin
                     state_in = ST_COPY;
                  end
                  lmpd_pkg::KIND_REFRESH: begin
                     if (!stat.blanked) begin
                        cmd.phase_step = 1'b1;
                        cmd.row_rd     = 1'b1;
                        cmd.rd_row     = '0;
                        state_in       = ST_REFRESH;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_DRAW_RD: begin
            cmd.draw_rd = 1'b1;
            state_in    = ST_DRAW_WR;
         end
         ST_DRAW_WR: begin
            cmd.draw_wr = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_COPY: begin
            // read row n while row n-1 goes into the shown store
            cmd.copy_rd = (cnt_ff != lmpd_pkg::CNT_W'(lmpd_pkg::ROWS));
            cmd.copy_wr = (cnt_ff != '0);
            if (cnt_ff == lmpd_pkg::CNT_W'(lmpd_pkg::ROWS)) begin
               cmd.frame_end = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + lmpd_pkg::CNT_W'(1);
            end
         end
         ST_REFRESH: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_last = (cnt_ff == lmpd_pkg::CNT_W'(lmpd_pkg::ROWS - 1));
               if (cmd.out_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cnt_in     = cnt_ff + lmpd_pkg::CNT_W'(1);
                  cmd.row_rd = 1'b1;
                  cmd.rd_row = cnt_row + lmpd_pkg::ROW_AW'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

/* sv/lmpd_datapath.sv */
module lmpd_datapath (
   input  logic               clock,
   input  logic               reset,
   input  logic signed [15:0] req_pixel_x,
   input  logic signed [15:0] req_pixel_y,
   input  logic [15:0]        req_pixel_value,
   input  logic               rsp_stall,
   input  lmpd_pkg::cmd_type  cmd,
   output lmpd_pkg::stat_type stat,
   output logic               rsp_valid,
   output logic [15:0]        rsp_shift_bits,
   output logic               rsp_latch
);

   logic [lmpd_pkg::ADDR_W-1:0]   addr_ff, addr_in;
   lmpd_pkg::pix_type             level_ff, level_in;
   logic [7:0]                    clamp;
   logic [lmpd_pkg::ROWS-1:0]     draw_vld_ff, draw_vld_in;
   logic [lmpd_pkg::ROWS-1:0]     shown_vld_ff, shown_vld_in;
   logic [lmpd_pkg::PWM_BITS-1:0] phase_ff, phase_in;
   logic                          blank_ff, blank_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [15:0]                   shift_ff, shift_in;
   logic                          latch_ff, latch_in;

   logic [lmpd_pkg::ROW_AW-1:0]   addr_row;
   logic [lmpd_pkg::COL_AW-1:0]   addr_col;
   logic [lmpd_pkg::ROW_AW-1:0]   vld_idx;
   logic [lmpd_pkg::ROW_AW-1:0]   draw_rd_addr;
   logic                          draw_rd_en;
   logic [lmpd_pkg::ROW_W-1:0]    draw_rd_data;
   logic [lmpd_pkg::ROW_W-1:0]    shown_rd_data;
   lmpd_pkg::row_type             draw_row, mod_row, shown_row;
   logic [lmpd_pkg::ROW_PIX-1:0]  bits;

   assign addr_row = addr_ff[lmpd_pkg::ADDR_W-1:lmpd_pkg::COL_AW];
   assign addr_col = addr_ff[lmpd_pkg::COL_AW-1:0];

   // negative coordinates carry high bits, so one test covers both ends
   assign stat.in_range = (req_pixel_x[15:4] == '0) && (req_pixel_y[15:4] == '0);
   assign stat.blanked  = blank_ff;
   assign stat.out_free = !rsp_valid_ff || !rsp_stall;

   assign clamp = (|req_pixel_value[15:8]) ? 8'hFF : req_pixel_value[7:0];

   assign vld_idx      = cmd.draw_wr ? addr_row : cmd.prev_row;
   assign draw_rd_en   = cmd.draw_rd || cmd.copy_rd;
   assign draw_rd_addr = cmd.draw_rd ? addr_row : cmd.rd_row;

   always_comb begin
      draw_row  = draw_vld_ff[vld_idx] ? draw_rd_data : '0;
      mod_row   = draw_row;
      mod_row[addr_col] = level_ff;
      shown_row = shown_vld_ff[cmd.row] ? shown_rd_data : '0;
      for (int j = 0; j < lmpd_pkg::ROW_PIX; j++) begin
         bits[j] = lmpd_pkg::CMP_W'(shown_row[j]) > lmpd_pkg::CMP_W'(phase_ff);
      end
   end

   lmpd_ram #(
      .WIDTH(lmpd_pkg::ROW_W),
      .DEPTH(lmpd_pkg::ROWS)
   ) u_draw_ram (
      .clock   (clock),
      .wr_en   (cmd.draw_wr),
      .wr_addr (addr_row),
      .wr_data (mod_row),
      .rd_en   (draw_rd_en),
      .rd_addr (draw_rd_addr),
      .rd_data (draw_rd_data)
   );

   lmpd_ram #(
      .WIDTH(lmpd_pkg::ROW_W),
      .DEPTH(lmpd_pkg::ROWS)
   ) u_shown_ram (
      .clock   (clock),
      .wr_en   (cmd.copy_wr),
      .wr_addr (cmd.prev_row),
      .wr_data (draw_row),
      .rd_en   (cmd.row_rd),
      .rd_addr (cmd.rd_row),
      .rd_data (shown_rd_data)
   );

   always_comb begin
      addr_in      = cmd.capture ? lmpd_pkg::serp_addr(req_pixel_x[3:0], req_pixel_y[3:0])
                                 : addr_ff;
      level_in     = cmd.capture ? lmpd_pkg::GAMMA_ROM[clamp] : level_ff;
      draw_vld_in  = draw_vld_ff;
      if (cmd.draw_wr) begin
         draw_vld_in[addr_row] = 1'b1;
      end
      shown_vld_in = cmd.frame_end ? '1 : shown_vld_ff;
      blank_in     = cmd.frame_end ? 1'b0 : blank_ff;
      phase_in     = cmd.phase_step ? phase_ff + lmpd_pkg::PWM_BITS'(1) : phase_ff;
      rsp_valid_in = cmd.out_load || (rsp_valid_ff && rsp_stall);
      shift_in     = cmd.out_load ? bits : shift_ff;
      latch_in     = cmd.out_load ? cmd.out_last : latch_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         draw_vld_ff  <= '0;
         shown_vld_ff <= '0;
         phase_ff     <= '0;
         blank_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         draw_vld_ff  <= draw_vld_in;
         shown_vld_ff <= shown_vld_in;
         phase_ff     <= phase_in;
         blank_ff     <= blank_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff  <= addr_in;
      level_ff <= level_in;
      shift_ff <= shift_in;
      latch_ff <= latch_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_shift_bits = shift_ff;
   assign rsp_latch      = latch_ff;

endmodule

/* sv/led_matrix_pwm_frame_driver_core.sv */
// draw: accept, then a read of the stored row, then the modified row is written back; no output word
// show: one row of 16 pixels copied per cycle through the store read port
// refresh: row 0 is read at accept, then one word per cycle while the output does not stall;
//   set by the shown store reading one 16-pixel row per cycle
// reset (sync, active high): stores read as zero via per-row valid bits, phase zero,
//   blanked set, output empty; no clearing pass
module led_matrix_pwm_frame_driver_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_kind,
   input  logic signed [15:0] req_pixel_x,
   input  logic signed [15:0] req_pixel_y,
   input  logic [15:0]        req_pixel_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [15:0]        rsp_shift_bits,
   output logic               rsp_latch
);

   lmpd_pkg::cmd_type  cmd;
   lmpd_pkg::stat_type stat;

   lmpd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   lmpd_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_pixel_x     (req_pixel_x),
      .req_pixel_y     (req_pixel_y),
      .req_pixel_value (req_pixel_value),
      .rsp_stall       (rsp_stall),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_valid       (rsp_valid),
      .rsp_shift_bits  (rsp_shift_bits),
      .rsp_latch       (rsp_latch)
   );

endmodule

/* sv/lmpd_checker.sv */
module lmpd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [1:0]  req_kind,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_shift_bits,
   input logic        rsp_latch
);

   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("block not idle after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_shift_bits) && $stable(rsp_latch)))
      else $error("stalled word changed");

   a_show_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_kind == lmpd_pkg::KIND_SHOW) |=> req_stall)
      else $error("show did not start frame copy");

   a_word_burst: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_latch) |=> rsp_valid)
      else $error("gap inside refresh burst");

endmodule

bind led_matrix_pwm_frame_driver_core lmpd_checker u_checker (.*);

/* tb/tb_led_matrix_pwm_frame_driver_core.sv */
`timescale 1ns / 1ps

module tb_led_matrix_pwm_frame_driver_core;

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 40;
   localparam int RANDOM_ITEMS = 310;

   typedef struct {
      logic [1:0]         kind;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [15:0]        value;
   } panel_cmd_type;

   typedef struct {
      logic [15:0] bits;
      logic        latch;
   } scan_word_type;

   logic               clock;
   logic               reset           = 1'b1;
   logic               req_valid       = 1'b0;
   logic               req_stall;
   logic [1:0]         req_kind        = lmpd_pkg::KIND_DRAW;
   logic signed [15:0] req_pixel_x     = '0;
   logic signed [15:0] req_pixel_y     = '0;
   logic [15:0]        req_pixel_value = '0;
   logic               rsp_valid;
   logic               rsp_stall       = 1'b0;
   logic [15:0]        rsp_shift_bits;
   logic               rsp_latch;

   // predictor state
   lmpd_pkg::pix_type             draw_lvl [256] = '{default: '0};
   lmpd_pkg::pix_type             shown_lvl [256] = '{default: '0};
   logic [lmpd_pkg::PWM_BITS-1:0] scan_phase = '0;
   logic                          panel_blanked = 1'b1;

   panel_cmd_type pending_cmds[$];
   scan_word_type expected_scan_words[$];
   panel_cmd_type live_cmd;
   scan_word_type want_word;

   int n_accepted  = 0;
   int n_total     = 0;
   int n_errors    = 0;
   int n_words     = 0;
   int send_gap    = 0;
   int stall_left  = 0;
   int stall_draw  = 0;
   int hold_left   = 0;
   int holds_done  = 0;
   int cycle_count = 0;

   led_matrix_pwm_frame_driver_core uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_pixel_x     (req_pixel_x),
      .req_pixel_y     (req_pixel_y),
      .req_pixel_value (req_pixel_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_shift_bits  (rsp_shift_bits),
      .rsp_latch       (rsp_latch)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // panel wiring: each 64-pixel block holds eight 8-pixel lines placed out of order,
   // odd line pairs run backwards
   function automatic logic [7:0] panel_slot(input logic [3:0] x, input logic [3:0] y);
      logic [7:0] lin;
      logic [5:0] line_base [8];
      logic [2:0] step;
      lin = {y, x};
      line_base = '{6'd0, 6'd16, 6'd8, 6'd24, 6'd48, 6'd32, 6'd56, 6'd40};
      step = lin[4] ? 3'd7 - lin[2:0] : lin[2:0];
      return {lin[7:6], line_base[lin[5:3]] + {3'd0, step}};
   endfunction

   task automatic apply_cmd(input panel_cmd_type c);
      logic [7:0]  grey;
      logic [15:0] bits;
      if (c.kind == lmpd_pkg::KIND_DRAW) begin
         if (c.x >= 0 && c.x < 16 && c.y >= 0 && c.y < 16) begin
            grey = (c.value > 16'd255) ? 8'd255 : c.value[7:0];
            draw_lvl[panel_slot(c.x[3:0], c.y[3:0])] = lmpd_pkg::GAMMA_ROM[grey];
         end
      end else if (c.kind == lmpd_pkg::KIND_SHOW) begin
         shown_lvl = draw_lvl;
         panel_blanked = 1'b0;
      end else if (c.kind == lmpd_pkg::KIND_REFRESH && !panel_blanked) begin
         scan_phase = scan_phase + 1'b1;
         for (int w = 0; w < 16; w++) begin
            bits = '0;
            for (int j = 0; j < 16; j++)
               bits[j] = int'(shown_lvl[w * 16 + j]) > int'(scan_phase);
            expected_scan_words.push_back('{bits: bits, latch: (w == 15)});
         end
      end
   endtask

   function automatic void push_cmd(input logic [1:0] kind, input int x, input int y,
                                    input int value);
      panel_cmd_type c;
      c.kind  = kind;
      c.x     = x[15:0];
      c.y     = y[15:0];
      c.value = value[15:0];
      pending_cmds.push_back(c);
   endfunction

   function automatic void push_random_draw();
      int x;
      int y;
      int v;
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) begin
         x = $urandom_range(0, 15);
         y = $urandom_range(0, 15);
      end else if (r < 90) begin
         x = $urandom_range(0, 65535);
         y = $urandom_range(0, 65535);
      end else begin
         x = $urandom_range(0, 1) ? 16 : -1;
         y = $urandom_range(0, 15);
         if ($urandom_range(0, 1)) begin
            y = x;
            x = $urandom_range(0, 15);
         end
      end
      r = $urandom_range(0, 99);
      if (r < 50)
         v = $urandom_range(0, 255);
      else if (r < 75)
         v = $urandom_range(0, 65535);
      else
         case ($urandom_range(0, 3))
            0:       v = 0;
            1:       v = 255;
            2:       v = 256;
            default: v = 65535;
         endcase
      push_cmd(lmpd_pkg::KIND_DRAW, x, y, v);
   endfunction

   // stretches with no random gaps on either side
   function automatic bit quiet_phase();
      return ((n_accepted / 50) % 3) == 1;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet_phase() || r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      if (n_errors < 40)
         $display("mismatch on word %0d, %s: got %h, expected %h", n_words, what, got, want);
      n_errors++;
   endtask

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            apply_cmd(live_cmd);
            n_accepted <= n_accepted + 1;
         end
         if (!req_valid || !req_stall) begin
            if (send_gap != 0) begin
               send_gap <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_cmds.size() != 0) begin
               live_cmd = pending_cmds.pop_front();
               req_kind <= live_cmd.kind;
               req_pixel_x <= live_cmd.x;
               req_pixel_y <= live_cmd.y;
               req_pixel_value <= live_cmd.value;
               req_valid <= 1'b1;
               send_gap <= pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long hold-off on the output so the block backs up
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (holds_done < 2 && n_accepted >= (holds_done == 0 ? 40 : 200)) begin
         hold_left <= HOLD_CYCLES;
         holds_done <= holds_done + 1;
      end
   end

   // receiver and checker
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_scan_words.size() == 0) begin
               report_mismatch("unexpected word", rsp_shift_bits, 16'h0);
            end else begin
               want_word = expected_scan_words.pop_front();
               if (rsp_shift_bits !== want_word.bits)
                  report_mismatch("shift_bits", rsp_shift_bits, want_word.bits);
               if (rsp_latch !== want_word.latch)
                  report_mismatch("latch", {15'd0, rsp_latch}, {15'd0, want_word.latch});
            end
            n_words <= n_words + 1;
         end
         if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            stall_draw = pick_gap();
            stall_left <= (stall_draw == 0) ? 0 : stall_draw - 1;
            rsp_stall <= (hold_left != 0) || (stall_draw != 0);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("led_matrix_pwm_frame_driver_core verification failed");
         $finish;
      end
   end

   initial begin
      int n_rand;
      int n_draw;
      int n_ref;

      // directed: blanked refresh, unused kind, field extremes, clamping, bad coordinates
      push_cmd(lmpd_pkg::KIND_REFRESH, 0, 0, 0);
      push_cmd(KIND_UNUSED, -1, -1, 65535);
      push_cmd(lmpd_pkg::KIND_DRAW, 0, 0, 65535);
      push_cmd(lmpd_pkg::KIND_DRAW, 15, 15, 256);
      push_cmd(lmpd_pkg::KIND_DRAW, 15, 0, 255);
      push_cmd(lmpd_pkg::KIND_DRAW, 0, 15, 1);
      push_cmd(lmpd_pkg::KIND_DRAW, 7, 3, 0);
      push_cmd(lmpd_pkg::KIND_DRAW, 8, 4, 128);
      push_cmd(lmpd_pkg::KIND_DRAW, 3, 11, 200);
      push_cmd(lmpd_pkg::KIND_DRAW, -1, 5, 200);
      push_cmd(lmpd_pkg::KIND_DRAW, 5, 16, 200);
      push_cmd(lmpd_pkg::KIND_DRAW, -32768, 32767, 255);
      push_cmd(lmpd_pkg::KIND_DRAW, 32767, -32768, 255);
      push_cmd(lmpd_pkg::KIND_DRAW, 16, -1, 100);
      push_cmd(lmpd_pkg::KIND_REFRESH, 0, 0, 0);
      push_cmd(lmpd_pkg::KIND_SHOW, 0, 0, 0);
      push_cmd(lmpd_pkg::KIND_REFRESH, 0, 0, 0);
      push_cmd(lmpd_pkg::KIND_REFRESH, 0, 0, 0);
      push_cmd(lmpd_pkg::KIND_DRAW, 1, 1, 255);
      push_cmd(lmpd_pkg::KIND_REFRESH, 0, 0, 0);
      push_cmd(KIND_UNUSED, 2, 2, 300);
      push_cmd(lmpd_pkg::KIND_SHOW, 0, 0, 0);
      push_cmd(lmpd_pkg::KIND_REFRESH, 0, 0, 0);

      // random frames: a few draws, usually a show, then a burst of refreshes
      n_rand = 0;
      while (n_rand < RANDOM_ITEMS) begin
         n_draw = $urandom_range(0, 10);
         for (int i = 0; i < n_draw; i++) begin
            if ($urandom_range(0, 99) < 5)
               push_cmd(KIND_UNUSED, $urandom_range(0, 65535), $urandom_range(0, 65535),
                        $urandom_range(0, 65535));
            else
               push_random_draw();
         end
         if ($urandom_range(0, 9) != 0) begin
            push_cmd(lmpd_pkg::KIND_SHOW, $urandom_range(0, 65535),
                     $urandom_range(0, 65535), $urandom_range(0, 65535));
            n_rand++;
         end
         n_ref = $urandom_range(1, 10);
         for (int i = 0; i < n_ref; i++)
            push_cmd(lmpd_pkg::KIND_REFRESH, $urandom_range(0, 65535),
                     $urandom_range(0, 65535), $urandom_range(0, 65535));
         n_rand += n_draw + n_ref;
      end
      n_total = pending_cmds.size();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (n_accepted != n_total) @(posedge clock);
      while (expected_scan_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (n_errors == 0 && expected_scan_words.size() == 0)
         $display("led_matrix_pwm_frame_driver_core verification clean");
      else
         $display("led_matrix_pwm_frame_driver_core verification failed");
      $finish;
   end

endmodule
